[design/kmrg_pkg.sv]
// Package for the k-way run merge selector.
// Holds the shared widths, codes and the result bundle; no dependencies.
`timescale 1ns / 1ps

package kmrg_pkg;

  localparam int MaxRuns     = 8;
  localparam int RunW        = 3;
  localparam int LenW        = 32;
  localparam int KeyMaxW     = 64;
  localparam int CfgIdxW     = 4;
  localparam int NumRunsDef  = 8;
  localparam int KeyBytesDef = 8;

  typedef enum logic {
    OpLoad   = 1'b0,
    OpSelect = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    StEmit    = 2'd0,
    StDone    = 2'd1,
    StMissing = 2'd2,
    StLoaded  = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [RunW-1:0]     run;
    logic [KeyMaxW-1:0]  key;
    logic [LenW-1:0]     pos;
  } res_t;

endpackage

[design/kmrg_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module kmrg_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                 clk_i,
  input  logic                                 we_i,
  input  logic [(Depth > 1 ? $clog2(Depth) : 1)-1:0] addr_i,
  input  logic [Width-1:0]                     wdata_i,
  output logic [Width-1:0]                     rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[design/kmrg_ctrl.sv]
// Sequencer of the merge selector: loads heads, scans the runs through the
// key and position memories and writes back. Depends on kmrg_pkg and kmrg_ram.
`timescale 1ns / 1ps

module kmrg_ctrl #(
  parameter int NUM_RUNS  = kmrg_pkg::NumRunsDef,
  parameter int KEY_BYTES = kmrg_pkg::KeyBytesDef
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         start,
  output logic                                         busy_o,
  input  logic                                         operation_i,
  input  logic [kmrg_pkg::RunW-1:0]                    run_index_i,
  input  logic [kmrg_pkg::KeyMaxW-1:0]                 head_key_i,
  input  logic [kmrg_pkg::MaxRuns-1:0][kmrg_pkg::LenW-1:0] len_i,
  output logic                                         result_strobe_o,
  output kmrg_pkg::res_t                               res_o
);

  localparam int KeyW  = 8 * KEY_BYTES;
  localparam int AddrW = (NUM_RUNS > 1) ? $clog2(NUM_RUNS) : 1;
  localparam int IssW  = kmrg_pkg::RunW + 1;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SScan = 3'b010,
    SFin  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic [IssW-1:0]                  iss_q, iss_d;
  logic                             ev_vld_q, ev_vld_d;
  logic [kmrg_pkg::RunW-1:0]        ev_idx_q, ev_idx_d;
  logic                             found_q, found_d;
  logic [kmrg_pkg::RunW-1:0]        best_q, best_d;
  logic [KeyW-1:0]                  best_key_q, best_key_d;
  logic [kmrg_pkg::LenW-1:0]        best_pos_q, best_pos_d;
  logic [kmrg_pkg::MaxRuns-1:0]     hv_q, hv_d;
  logic [kmrg_pkg::MaxRuns-1:0]     pw_q, pw_d;
  logic [kmrg_pkg::LenW-1:0]        cnt_q, cnt_d;
  logic                             strobe_q, strobe_d;
  kmrg_pkg::res_t                   res_q, res_d;

  logic                             key_we;
  logic [AddrW-1:0]                 key_addr;
  logic [KeyW-1:0]                  key_rdata;
  logic                             pos_we;
  logic [AddrW-1:0]                 pos_addr;
  logic [kmrg_pkg::LenW-1:0]        pos_wdata;
  logic [kmrg_pkg::LenW-1:0]        pos_rdata;
  logic [kmrg_pkg::LenW-1:0]        pos_cur;
  logic                             live;

  kmrg_ram #(.Width(KeyW), .Depth(NUM_RUNS)) u_key_ram (
    .clk_i  (clk_i),
    .we_i   (key_we),
    .addr_i (key_addr),
    .wdata_i(head_key_i[KeyW-1:0]),
    .rdata_o(key_rdata)
  );

  kmrg_ram #(.Width(kmrg_pkg::LenW), .Depth(NUM_RUNS)) u_pos_ram (
    .clk_i  (clk_i),
    .we_i   (pos_we),
    .addr_i (pos_addr),
    .wdata_i(pos_wdata),
    .rdata_o(pos_rdata)
  );

  assign pos_cur = pw_q[ev_idx_q] ? pos_rdata : '0;
  assign live    = pos_cur < len_i[ev_idx_q];

  always_comb begin
    state_d    = state_q;
    iss_d      = iss_q;
    ev_vld_d   = 1'b0;
    ev_idx_d   = ev_idx_q;
    found_d    = found_q;
    best_d     = best_q;
    best_key_d = best_key_q;
    best_pos_d = best_pos_q;
    hv_d       = hv_q;
    pw_d       = pw_q;
    cnt_d      = cnt_q;
    strobe_d   = 1'b0;
    res_d      = res_q;
    key_we     = 1'b0;
    key_addr   = AddrW'(iss_q[kmrg_pkg::RunW-1:0]);
    pos_we     = 1'b0;
    pos_addr   = AddrW'(iss_q[kmrg_pkg::RunW-1:0]);
    pos_wdata  = best_pos_q + kmrg_pkg::LenW'(1);

    case (state_q)
      SIdle: begin
        if (start) begin
          if (operation_i == kmrg_pkg::OpLoad) begin
            if (32'(run_index_i) < 32'(NUM_RUNS)) begin
              key_we            = 1'b1;
              key_addr          = AddrW'(run_index_i);
              hv_d[run_index_i] = 1'b1;
            end
            strobe_d     = 1'b1;
            res_d.status = kmrg_pkg::StLoaded;
            res_d.run    = run_index_i;
            res_d.key    = '0;
            res_d.pos    = '0;
          end else begin
            state_d = SScan;
            iss_d   = '0;
            found_d = 1'b0;
          end
        end
      end
      SScan: begin
        if (iss_q < IssW'(NUM_RUNS)) begin
          ev_vld_d = 1'b1;
          ev_idx_d = iss_q[kmrg_pkg::RunW-1:0];
          iss_d    = iss_q + IssW'(1);
        end
        if (ev_vld_q) begin
          if (live && !hv_q[ev_idx_q]) begin
            strobe_d     = 1'b1;
            res_d.status = kmrg_pkg::StMissing;
            res_d.run    = ev_idx_q;
            res_d.key    = '0;
            res_d.pos    = '0;
            ev_vld_d     = 1'b0;
            state_d      = SIdle;
          end else begin
            if (live && (!found_q || key_rdata <= best_key_q)) begin
              found_d    = 1'b1;
              best_d     = ev_idx_q;
              best_key_d = key_rdata;
              best_pos_d = pos_cur;
            end
            if (ev_idx_q == kmrg_pkg::RunW'(NUM_RUNS - 1)) begin
              state_d = SFin;
            end
          end
        end
      end
      SFin: begin
        state_d  = SIdle;
        strobe_d = 1'b1;
        if (found_q) begin
          res_d.status = kmrg_pkg::StEmit;
          res_d.run    = best_q;
          res_d.key    = kmrg_pkg::KeyMaxW'(best_key_q);
          res_d.pos    = cnt_q;
          cnt_d        = cnt_q + kmrg_pkg::LenW'(1);
          pos_we       = 1'b1;
          pos_addr     = AddrW'(best_q);
          hv_d[best_q] = 1'b0;
          pw_d[best_q] = 1'b1;
        end else begin
          res_d.status = kmrg_pkg::StDone;
          res_d.run    = '0;
          res_d.key    = '0;
          res_d.pos    = '0;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= SIdle;
      iss_q    <= '0;
      ev_vld_q <= 1'b0;
      found_q  <= 1'b0;
      hv_q     <= '0;
      pw_q     <= '0;
      cnt_q    <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      iss_q    <= iss_d;
      ev_vld_q <= ev_vld_d;
      found_q  <= found_d;
      hv_q     <= hv_d;
      pw_q     <= pw_d;
      cnt_q    <= cnt_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ev_idx_q   <= ev_idx_d;
    best_q     <= best_d;
    best_key_q <= best_key_d;
    best_pos_q <= best_pos_d;
    res_q      <= res_d;
  end

  assign busy_o          = (state_q != SIdle);
  assign result_strobe_o = strobe_q;
  assign res_o           = res_q;

endmodule

[design/kway_run_merge_selector_unit.sv]
// Top level of the k-way run merge selector: run length registers and the
// sequencer. Depends on kmrg_pkg and kmrg_ctrl.
//
// Usage: configuration words (index 0 to 7, run lengths in blocks) are written
// on the cfg channel, which is always ready, while the block is idle; an index
// above seven is ignored. A command word is taken at a clock edge with start
// high and busy low. A load word stores a head key and answers in the next
// cycle, with busy staying low, so loads can be issued every cycle. A select
// word raises busy and scans the runs one per cycle through the key and
// position memories; its result follows the compare of the last run, or comes
// earlier when a run with a missing head is met. Each memory has a single read
// port, so the scan reads one run at a time. Each result word is shown for
// exactly one cycle with result_strobe_o high; the receiver cannot stall it.
// Reset clears the run lengths, head valid flags, run positions and the
// output counter; the key memory is not cleared.
`timescale 1ns / 1ps

module kway_run_merge_selector_unit #(
  parameter int NUM_RUNS  = kmrg_pkg::NumRunsDef,
  parameter int KEY_BYTES = kmrg_pkg::KeyBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [kmrg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [kmrg_pkg::LenW-1:0]     cfg_data_i,
  input  logic                          start,
  output logic                          busy,
  input  logic                          operation_i,
  input  logic [kmrg_pkg::RunW-1:0]     run_index_i,
  input  logic [kmrg_pkg::KeyMaxW-1:0]  head_key_i,
  output logic                          result_strobe_o,
  output logic [1:0]                    status_o,
  output logic [kmrg_pkg::RunW-1:0]     chosen_run_o,
  output logic [kmrg_pkg::KeyMaxW-1:0]  out_key_o,
  output logic [kmrg_pkg::LenW-1:0]     out_position_o
);

  logic [kmrg_pkg::MaxRuns-1:0][kmrg_pkg::LenW-1:0] len_q;
  kmrg_pkg::res_t res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
    end else if (cfg_valid_i && cfg_index_i < kmrg_pkg::CfgIdxW'(kmrg_pkg::MaxRuns)) begin
      len_q[cfg_index_i[kmrg_pkg::RunW-1:0]] <= cfg_data_i;
    end
  end

  kmrg_ctrl #(
    .NUM_RUNS (NUM_RUNS),
    .KEY_BYTES(KEY_BYTES)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy_o         (busy),
    .operation_i    (operation_i),
    .run_index_i    (run_index_i),
    .head_key_i     (head_key_i),
    .len_i          (len_q),
    .result_strobe_o(result_strobe_o),
    .res_o          (res)
  );

  assign status_o       = res.status;
  assign chosen_run_o   = res.run;
  assign out_key_o      = res.key;
  assign out_position_o = res.pos;

endmodule
